FILE: rtl/button_debounce_press_hold_events_unit_defines.svh
// ---------------------------------------------------------------------------
// Button debounce event unit assertion macros
// Shared concurrent assertion forms for the button debounce event unit.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_EVENTS_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_EVENTS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTNDB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTNDB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/btndb_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce package
// Event codes, button numbers, register map and the event word type.
// ---------------------------------------------------------------------------
package btndb_pkg;

   localparam int NUM_BTN = 3;

   localparam logic [1:0] BTN_UP     = 2'd0;
   localparam logic [1:0] BTN_ACTION = 2'd1;
   localparam logic [1:0] BTN_DOWN   = 2'd2;

   localparam logic [1:0] KIND_SHORT = 2'd0;
   localparam logic [1:0] KIND_HOLD  = 2'd1;
   localparam logic [1:0] KIND_COMBO = 2'd2;

   localparam int CFG_WIDTH  = 16;
   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 32;
   localparam int IN_TIME_WIDTH = 32;

   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_HOLD     = 2'd1;
   localparam logic [1:0] REG_COMBO    = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd30;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] COMBO_RESET    = 16'd2000;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [1:0] code;
      logic       combo;
   } evt_type;

endpackage

FILE: rtl/btndb_req_if.sv
// ---------------------------------------------------------------------------
// Button poll channel
// Valid/ready channel carrying one poll word: three raw levels and a time.
// ---------------------------------------------------------------------------
interface btndb_req_if;
   logic        valid;
   logic        ready;
   logic        up_pressed;
   logic        action_pressed;
   logic        down_pressed;
   logic [31:0] time_now;

   modport source (output valid, output up_pressed, output action_pressed,
                   output down_pressed, output time_now, input ready);
   modport sink (input valid, input up_pressed, input action_pressed,
                 input down_pressed, input time_now, output ready);
endinterface

FILE: rtl/btndb_rsp_if.sv
// ---------------------------------------------------------------------------
// Button event channel
// Valid/ready channel carrying one event word.
// ---------------------------------------------------------------------------
interface btndb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [1:0] button_code;
   logic       is_combo;

   modport source (output valid, output event_kind, output button_code,
                   output is_combo, input ready);
   modport sink (input valid, input event_kind, input button_code,
                 input is_combo, output ready);
endinterface

FILE: rtl/btndb_step.sv
// ---------------------------------------------------------------------------
// Button debounce poll step
// Next state and event for one poll, buttons in order up, action, down.
// ---------------------------------------------------------------------------
module btndb_step #(
   parameter int TIME_WIDTH = 32
) (
   input  logic [2:0]                                raw,
   input  logic [TIME_WIDTH-1:0]                     now,
   input  logic [btndb_pkg::CFG_WIDTH-1:0]           debounce_time,
   input  logic [btndb_pkg::CFG_WIDTH-1:0]           hold_time,
   input  logic [btndb_pkg::CFG_WIDTH-1:0]           combo_time,
   input  logic [2:0]                                last_raw,
   input  logic [2:0]                                stable_level,
   input  logic [TIME_WIDTH-1:0]                     change_time [3],
   input  logic [TIME_WIDTH-1:0]                     press_start [3],
   input  logic [2:0]                                hold_done,
   input  logic                                      combo_done,
   output logic [2:0]                                last_raw_n,
   output logic [2:0]                                stable_level_n,
   output logic [TIME_WIDTH-1:0]                     change_time_n [3],
   output logic [TIME_WIDTH-1:0]                     press_start_n [3],
   output logic [2:0]                                hold_done_n,
   output logic                                      combo_done_n,
   output btndb_pkg::evt_type                        evt
);

   logic                  stop;
   logic [TIME_WIDTH-1:0] elapsed;
   logic [TIME_WIDTH-1:0] later;

   always_comb begin
      last_raw_n     = last_raw;
      stable_level_n = stable_level;
      change_time_n  = change_time;
      press_start_n  = press_start;
      hold_done_n    = hold_done;
      combo_done_n   = combo_done;
      evt            = '0;
      stop           = 1'b0;
      elapsed        = '0;
      later          = '0;
      for (int b = 0; b < btndb_pkg::NUM_BTN; b++) begin
         if (!stop) begin
            if (raw[b] != last_raw_n[b]) begin
               change_time_n[b] = now;
               last_raw_n[b]    = raw[b];
            end
            elapsed = now - change_time_n[b];
            if (elapsed >= TIME_WIDTH'(debounce_time) && raw[b] != stable_level_n[b]) begin
               stable_level_n[b] = raw[b];
               if (raw[b]) begin
                  press_start_n[b] = now;
                  hold_done_n[b]   = 1'b0;
               end else if (!hold_done_n[b]) begin
                  evt.valid = 1'b1;
                  evt.kind  = btndb_pkg::KIND_SHORT;
                  evt.code  = 2'(b);
                  stop      = 1'b1;
               end
            end
            elapsed = now - press_start_n[b];
            if (!stop && 2'(b) == btndb_pkg::BTN_ACTION && stable_level_n[b] &&
                !hold_done_n[b] && elapsed >= TIME_WIDTH'(hold_time)) begin
               hold_done_n[b] = 1'b1;
               evt.valid      = 1'b1;
               evt.kind       = btndb_pkg::KIND_HOLD;
               evt.code       = btndb_pkg::BTN_ACTION;
               stop           = 1'b1;
            end
         end
      end
      if (!stop) begin
         if (stable_level_n[btndb_pkg::BTN_UP] && stable_level_n[btndb_pkg::BTN_DOWN]) begin
            later = (press_start_n[btndb_pkg::BTN_UP] > press_start_n[btndb_pkg::BTN_DOWN]) ?
                    press_start_n[btndb_pkg::BTN_UP] : press_start_n[btndb_pkg::BTN_DOWN];
            elapsed = now - later;
            if (!combo_done_n && elapsed >= TIME_WIDTH'(combo_time)) begin
               combo_done_n = 1'b1;
               evt.valid    = 1'b1;
               evt.kind     = btndb_pkg::KIND_COMBO;
               evt.code     = btndb_pkg::BTN_ACTION;
               evt.combo    = 1'b1;
            end
         end else begin
            combo_done_n = 1'b0;
         end
      end
   end

endmodule

FILE: rtl/button_debounce_press_hold_events_unit.sv
// ---------------------------------------------------------------------------
// Button debounce event unit
// Takes one poll word per clock cycle while the result register is not
// stalled and returns its event, if any: the poll is captured in an input
// register, the debounce, hold and combo update runs combinationally from
// it, button by button until the first event, and the event lands in a
// result register. Sustained rate is one poll per cycle; a stalled result
// register holds the next poll in the input register.
// ---------------------------------------------------------------------------
`include "button_debounce_press_hold_events_unit_defines.svh"

module button_debounce_press_hold_events_unit #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   btndb_req_if.sink                             req_chan,
   btndb_rsp_if.source                           rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [btndb_pkg::ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [btndb_pkg::DATA_WIDTH-1:0]      csr_pwdata,
   output logic [btndb_pkg::DATA_WIDTH-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   logic [btndb_pkg::CFG_WIDTH-1:0] debounce_ff;
   logic [btndb_pkg::CFG_WIDTH-1:0] hold_ff;
   logic [btndb_pkg::CFG_WIDTH-1:0] combo_ff;

   logic                  in_vld_ff;
   logic [2:0]            in_raw_ff;
   logic [TIME_WIDTH-1:0] in_time_ff;

   logic                  out_vld_ff;
   btndb_pkg::evt_type    out_evt_ff;

   logic [2:0]            last_raw_ff;
   logic [2:0]            stable_ff;
   logic [TIME_WIDTH-1:0] change_time_ff [3];
   logic [TIME_WIDTH-1:0] press_start_ff [3];
   logic [2:0]            hold_done_ff;
   logic                  combo_done_ff;

   logic [2:0]            last_raw_in;
   logic [2:0]            stable_in;
   logic [TIME_WIDTH-1:0] change_time_in [3];
   logic [TIME_WIDTH-1:0] press_start_in [3];
   logic [2:0]            hold_done_in;
   logic                  combo_done_in;
   btndb_pkg::evt_type    evt;

   logic fire;
   logic cfg_wr;
   logic [1:0] reg_idx;

   assign fire        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || fire;
   assign cfg_wr      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx     = csr_paddr[3:2];
   assign csr_pready  = 1'b1;

   always_comb begin
      case (reg_idx)
         btndb_pkg::REG_DEBOUNCE: csr_prdata = btndb_pkg::DATA_WIDTH'(debounce_ff);
         btndb_pkg::REG_HOLD:     csr_prdata = btndb_pkg::DATA_WIDTH'(hold_ff);
         btndb_pkg::REG_COMBO:    csr_prdata = btndb_pkg::DATA_WIDTH'(combo_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= btndb_pkg::DEBOUNCE_RESET;
         hold_ff     <= btndb_pkg::HOLD_RESET;
         combo_ff    <= btndb_pkg::COMBO_RESET;
      end else if (cfg_wr) begin
         case (reg_idx)
            btndb_pkg::REG_DEBOUNCE: debounce_ff <= csr_pwdata[btndb_pkg::CFG_WIDTH-1:0];
            btndb_pkg::REG_HOLD:     hold_ff     <= csr_pwdata[btndb_pkg::CFG_WIDTH-1:0];
            btndb_pkg::REG_COMBO:    combo_ff    <= csr_pwdata[btndb_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_raw_ff  <= {req_chan.down_pressed, req_chan.action_pressed, req_chan.up_pressed};
         in_time_ff <= TIME_WIDTH'(req_chan.time_now);
      end
      if (fire) begin
         out_evt_ff <= evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (fire) begin
            out_vld_ff <= evt.valid;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= '0;
         stable_ff      <= '0;
         change_time_ff <= '{default: '0};
         press_start_ff <= '{default: '0};
         hold_done_ff   <= '0;
         combo_done_ff  <= 1'b0;
      end else if (fire) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
         hold_done_ff   <= hold_done_in;
         combo_done_ff  <= combo_done_in;
      end
   end

   btndb_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .raw            (in_raw_ff),
      .now            (in_time_ff),
      .debounce_time  (debounce_ff),
      .hold_time      (hold_ff),
      .combo_time     (combo_ff),
      .last_raw       (last_raw_ff),
      .stable_level   (stable_ff),
      .change_time    (change_time_ff),
      .press_start    (press_start_ff),
      .hold_done      (hold_done_ff),
      .combo_done     (combo_done_ff),
      .last_raw_n     (last_raw_in),
      .stable_level_n (stable_in),
      .change_time_n  (change_time_in),
      .press_start_n  (press_start_in),
      .hold_done_n    (hold_done_in),
      .combo_done_n   (combo_done_in),
      .evt            (evt)
   );

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.event_kind  = out_evt_ff.kind;
   assign rsp_chan.button_code = out_evt_ff.code;
   assign rsp_chan.is_combo    = out_evt_ff.combo;

   `BTNDB_ASSERT_NEXT(a_evt_to_out, clock, reset, fire && evt.valid, out_vld_ff, "event word lost")
   `BTNDB_ASSERT_NEXT(a_combo_state, clock, reset, fire && evt.valid && evt.combo, stable_ff[btndb_pkg::BTN_UP] && stable_ff[btndb_pkg::BTN_DOWN] && combo_done_ff, "combo without both buttons held")
   `BTNDB_ASSERT_NEXT(a_hold_marks, clock, reset, fire && evt.valid && evt.kind == btndb_pkg::KIND_HOLD, hold_done_ff[btndb_pkg::BTN_ACTION], "hold event did not mark hold done")
   `BTNDB_ASSERT_SAME(a_empty_ready, clock, reset, !in_vld_ff, req_chan.ready, "empty input stage not ready")

endmodule

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// Button debounce event unit testbench
// Sends poll words of three raw button levels and a millisecond stamp, and
// predicts each short press, hold and combo event from a behavioral copy of
// the debounce state. Events are checked in order, field by field. The poll
// and event channels stall at random. Registers are written and read back
// between phases, which cover the reset settings, both extremes of every
// register and a spread of small settings, with stamps that wrap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] code;
      logic       combo;
   } btn_event_type;

   typedef struct packed {
      logic [2:0]  lvl;
      logic [31:0] stamp;
   } poll_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [btndb_pkg::ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [btndb_pkg::DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [btndb_pkg::DATA_WIDTH-1:0] csr_prdata;
   logic                             csr_pready;

   btndb_req_if poll_if ();
   btndb_rsp_if event_if ();

   button_debounce_press_hold_events_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (poll_if),
      .rsp_chan    (event_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Debounce state of the predictor; index 0 is up, 1 action, 2 down.
   logic [2:0]  last_raw = '0;
   logic [2:0]  stable_lvl = '0;
   logic [2:0]  hold_done = '0;
   logic [31:0] change_ms [btndb_pkg::NUM_BTN] = '{default: '0};
   logic [31:0] press_ms [btndb_pkg::NUM_BTN] = '{default: '0};
   logic        combo_done = 1'b0;
   logic [15:0] cfg_debounce = btndb_pkg::DEBOUNCE_RESET;
   logic [15:0] cfg_hold = btndb_pkg::HOLD_RESET;
   logic [15:0] cfg_combo = btndb_pkg::COMBO_RESET;

   poll_type       poll_backlog[$];
   btn_event_type  pending_events[$];
   int          polls_queued = 0;
   int          polls_taken = 0;
   logic        poll_fired = 1'b0;
   logic        calm = 1'b0;
   int          mismatches = 0;
   int          cycles = 0;
   int          n_short = 0;
   int          n_hold = 0;
   int          n_combo = 0;
   int          settings_used = 1;
   logic [31:0] sim_ms = '0;
   logic [2:0]  held = '0;

   task automatic advance_buttons(input poll_type p, output bit fired,
                                  output btn_event_type ev);
      logic [31:0] since;
      logic [31:0] later;
      fired = 1'b0;
      ev = '0;
      for (int b = 0; b < btndb_pkg::NUM_BTN; b++) begin
         if (p.lvl[b] != last_raw[b]) begin
            change_ms[b] = p.stamp;
            last_raw[b] = p.lvl[b];
         end
         since = p.stamp - change_ms[b];
         if (since >= {16'h0, cfg_debounce} && p.lvl[b] != stable_lvl[b]) begin
            stable_lvl[b] = p.lvl[b];
            if (p.lvl[b]) begin
               press_ms[b] = p.stamp;
               hold_done[b] = 1'b0;
            end else if (!hold_done[b]) begin
               fired = 1'b1;
               ev = '{btndb_pkg::KIND_SHORT, 2'(b), 1'b0};
               return;
            end
         end
         since = p.stamp - press_ms[b];
         if (2'(b) == btndb_pkg::BTN_ACTION && stable_lvl[b] && !hold_done[b] &&
             since >= {16'h0, cfg_hold}) begin
            hold_done[b] = 1'b1;
            fired = 1'b1;
            ev = '{btndb_pkg::KIND_HOLD, 2'(b), 1'b0};
            return;
         end
      end
      if (stable_lvl[btndb_pkg::BTN_UP] && stable_lvl[btndb_pkg::BTN_DOWN]) begin
         // The later start is picked by a plain unsigned compare, even across a wrap.
         later = (press_ms[btndb_pkg::BTN_UP] > press_ms[btndb_pkg::BTN_DOWN]) ?
                 press_ms[btndb_pkg::BTN_UP] : press_ms[btndb_pkg::BTN_DOWN];
         since = p.stamp - later;
         if (!combo_done && since >= {16'h0, cfg_combo}) begin
            combo_done = 1'b1;
            fired = 1'b1;
            ev = '{btndb_pkg::KIND_COMBO, btndb_pkg::BTN_ACTION, 1'b1};
         end
      end else begin
         combo_done = 1'b0;
      end
   endtask

   task automatic queue_poll(input logic up, input logic act, input logic down,
                             input logic [31:0] stamp);
      poll_backlog.push_back('{{down, act, up}, stamp});
      polls_queued++;
   endtask

   task automatic random_polls(input int count, input int unsigned max_step);
      int unsigned pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            queue_poll(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom);
         end else begin
            sim_ms += (pick < 14) ? $urandom_range(4 * max_step) : $urandom_range(max_step);
            for (int b = 0; b < btndb_pkg::NUM_BTN; b++) begin
               if ($urandom_range(99) < 10) held[b] = ~held[b];
            end
            queue_poll(held[0], held[1], held[2], sim_ms);
         end
      end
   endtask

   task automatic program_reg(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      case (idx)
         btndb_pkg::REG_DEBOUNCE: cfg_debounce = value;
         btndb_pkg::REG_HOLD: cfg_hold = value;
         btndb_pkg::REG_COMBO: cfg_combo = value;
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx != REG_SPARE) begin
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata[15:0] !== value) begin
            $display("%0t: register %0d read back expected %0d actual %0d",
                     $time, idx, value, csr_prdata[15:0]);
            mismatches++;
         end
         @(negedge clock);
         csr_penable <= 1'b0;
      end
      csr_psel <= 1'b0;
      settings_used++;
   endtask

   task automatic drain;
      do @(negedge clock); while (polls_taken != polls_queued || pending_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      poll_type p;
      if (!reset && (!poll_if.valid || poll_fired)) begin
         if (poll_backlog.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
            p = poll_backlog.pop_front();
            poll_if.valid <= 1'b1;
            poll_if.up_pressed <= p.lvl[0];
            poll_if.action_pressed <= p.lvl[1];
            poll_if.down_pressed <= p.lvl[2];
            poll_if.time_now <= p.stamp;
         end else begin
            poll_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      event_if.ready <= calm || ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      btn_event_type want;
      btn_event_type got;
      btn_event_type made;
      bit fired;
      if (reset) begin
         poll_fired <= 1'b0;
      end else begin
         if (event_if.valid && event_if.ready) begin
            got = '{event_if.event_kind, event_if.button_code, event_if.is_combo};
            if (pending_events.size() == 0) begin
               $display("%0t: event word with none expected: kind %0d code %0d combo %0d",
                        $time, got.kind, got.code, got.combo);
               mismatches++;
            end else begin
               want = pending_events.pop_front();
               if (got.kind !== want.kind) begin
                  $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, got.kind);
                  mismatches++;
               end
               if (got.code !== want.code) begin
                  $display("%0t: button_code expected %0d actual %0d", $time, want.code, got.code);
                  mismatches++;
               end
               if (got.combo !== want.combo) begin
                  $display("%0t: is_combo expected %0d actual %0d", $time, want.combo, got.combo);
                  mismatches++;
               end
               case (want.kind)
                  btndb_pkg::KIND_SHORT: n_short++;
                  btndb_pkg::KIND_HOLD: n_hold++;
                  default: n_combo++;
               endcase
            end
         end
         if (poll_if.valid && poll_if.ready) begin
            advance_buttons('{{poll_if.down_pressed, poll_if.action_pressed, poll_if.up_pressed},
                              poll_if.time_now}, fired, made);
            if (fired) pending_events.push_back(made);
            polls_taken <= polls_taken + 1;
         end
         poll_fired <= poll_if.valid && poll_if.ready;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d polls outstanding and %0d events expected",
                  $time, polls_queued - polls_taken, pending_events.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      poll_if.valid = 1'b0;
      poll_if.up_pressed = 1'b0;
      poll_if.action_pressed = 1'b0;
      poll_if.down_pressed = 1'b0;
      poll_if.time_now = '0;
      event_if.ready = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a short press on each button, a hold followed by a
      // silent release, then a combo across the stamp wrap, a short up release,
      // and a combo that fires at once because the up press after the wrap
      // compares lower than the down press before it.
      queue_poll(0, 0, 0, 32'd0);
      queue_poll(1, 0, 0, 32'd5);
      queue_poll(1, 0, 0, 32'd40);
      queue_poll(0, 0, 0, 32'd50);
      queue_poll(0, 0, 0, 32'd85);
      queue_poll(0, 1, 0, 32'd100);
      queue_poll(0, 1, 0, 32'd140);
      queue_poll(0, 1, 0, 32'd1140);
      queue_poll(0, 0, 0, 32'd1150);
      queue_poll(0, 0, 0, 32'd1200);
      queue_poll(0, 1, 0, 32'd1300);
      queue_poll(0, 1, 0, 32'd1340);
      queue_poll(0, 0, 0, 32'd1400);
      queue_poll(0, 0, 0, 32'd1440);
      queue_poll(0, 0, 1, 32'd1500);
      queue_poll(0, 0, 1, 32'd1540);
      queue_poll(0, 0, 0, 32'd1600);
      queue_poll(0, 0, 0, 32'd1640);
      queue_poll(1, 0, 1, 32'hFFFF_FF00);
      queue_poll(1, 0, 1, 32'hFFFF_FF20);
      queue_poll(1, 0, 1, 32'h0000_06F0);
      queue_poll(0, 0, 1, 32'h0000_0700);
      queue_poll(0, 0, 1, 32'h0000_0730);
      queue_poll(1, 0, 1, 32'h0000_0740);
      queue_poll(1, 0, 1, 32'h0000_0770);
      held = 3'b101;
      sim_ms = 32'h0000_0770;
      drain;

      program_reg(btndb_pkg::REG_DEBOUNCE, 16'd0);
      program_reg(btndb_pkg::REG_HOLD, 16'd0);
      program_reg(btndb_pkg::REG_COMBO, 16'd0);
      program_reg(REG_SPARE, 16'hBEEF);
      random_polls(100, 3);
      drain;

      program_reg(btndb_pkg::REG_DEBOUNCE, 16'hFFFF);
      program_reg(btndb_pkg::REG_HOLD, 16'hFFFF);
      program_reg(btndb_pkg::REG_COMBO, 16'hFFFF);
      random_polls(80, 30000);
      drain;

      program_reg(btndb_pkg::REG_DEBOUNCE, 16'd5);
      program_reg(btndb_pkg::REG_HOLD, 16'd60);
      program_reg(btndb_pkg::REG_COMBO, 16'd90);
      sim_ms = 32'hFFFF_FFFF - $urandom_range(3000);
      random_polls(150, 12);
      drain;

      program_reg(btndb_pkg::REG_DEBOUNCE, 16'd10);
      program_reg(btndb_pkg::REG_HOLD, 16'd200);
      program_reg(btndb_pkg::REG_COMBO, 16'd150);
      calm = 1'b1;
      random_polls(150, 20);
      drain;
      calm = 1'b0;

      repeat (3) begin
         program_reg(btndb_pkg::REG_DEBOUNCE, 16'($urandom_range(20)));
         program_reg(btndb_pkg::REG_HOLD, 16'($urandom_range(300)));
         program_reg(btndb_pkg::REG_COMBO, 16'($urandom_range(300)));
         random_polls(100, 15);
         drain;
      end

      $display("Sent %0d polls over %0d register settings, stamps wrapping past zero.",
               polls_taken, settings_used);
      $display("Checked %0d short press, %0d hold and %0d combo events.",
               n_short, n_hold, n_combo);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
